### rtl/core/clep_pkg.sv
// Shared types and constants for the colour table entry packer.
package clep_pkg;

	// Configuration register indexes
	localparam logic [0:0] CFG_OUTPUT_FORMAT = 1'b0;
	localparam logic [0:0] CFG_TABLE_POINTS  = 1'b1;

	// Output format codes
	localparam logic FMT_TEN_BIT = 1'b0;
	localparam logic FMT_WIDE    = 1'b1;

	localparam logic [5:0] TABLE_POINTS_RST  = 6'd33;
	localparam logic [5:0] DOWNSAMPLE_POINTS = 6'd33;
	localparam logic [9:0] TOP10             = 10'd1023;
	localparam int unsigned PACKED_BITS      = 81;

	typedef struct packed {
		logic [31:0] red_bits;
		logic [31:0] green_bits;
		logic [31:0] blue_bits;
		logic        table_start;
	} entry_t;

	typedef struct packed {
		logic [63:0] packed_low;
		logic [16:0] packed_high;
		logic        saturated;
		logic        last_entry;
	} result_t;

	typedef struct packed {
		logic emit;
		logic last;
	} coord_info_t;

endpackage

### rtl/core/color_lut_entry_packer.sv
// Top level of the colour table entry packer.
// The block takes one 3D colour table entry per transfer (red, green and blue as IEEE
// single-precision bit patterns, red fastest) and returns its packed fixed-point form.
// With output_format 0 each channel becomes floor(value*1023) after single-precision
// rounding of the product, packed blue[29:20] green[19:10] red[9:0]; with output_format 1
// each channel becomes round-half-up of value*(2^CHANNEL_FRACTION_BITS-1), packed red,
// green, blue from bit 0 of an 81-bit word. Negative, NaN and out-of-range values clamp
// and set saturated. In wide mode with a 33-point table only entries whose coordinates are
// all even produce a result, giving a 17-point table; the other entries only advance the
// coordinates. table_start restarts the coordinates at the entry that carries it. Throughput
// is one entry per clock while results are taken; an input register and a result register
// frame a single stage of conversion logic. result_valid rises once an emitted entry has
// passed the input register and then the result register. While a finished result waits
// for result_ready the input side still takes entries until the input register holds one
// that produces a result; item_ready then stays low until the result register drains.
// Write the configuration only while no entry is in flight.
module color_lut_entry_packer #(
	parameter int unsigned CHANNEL_FRACTION_BITS = 27
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [0:0]       cfg_index,
	input  logic [5:0]       cfg_data,
	input  logic             item_valid,
	output logic             item_ready,
	input  clep_pkg::entry_t item,
	output logic             result_valid,
	input  logic             result_ready,
	output clep_pkg::result_t result
);
	import clep_pkg::*;

	localparam int unsigned F  = CHANNEL_FRACTION_BITS;
	localparam int unsigned CW = 3 * F;

	logic        output_format_q;
	logic [5:0]  table_points_q;

	logic        accept, adv_s1;
	coord_info_t info;

	logic        valid_s1, last_s1;
	logic [31:0] red_s1, green_s1, blue_s1;

	logic [9:0]   ten_r, ten_g, ten_b;
	logic [F-1:0] wide_r, wide_g, wide_b;
	logic         sat_r, sat_g, sat_b;
	logic [CW-1:0]          wide_cat;
	logic [PACKED_BITS-1:0] word;
	result_t     result_d;
	logic        res_valid_q;
	result_t     result_q;

	// Configuration registers: plain writes, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_format_q <= FMT_TEN_BIT;
			table_points_q  <= TABLE_POINTS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OUTPUT_FORMAT: output_format_q <= cfg_data[0];
				CFG_TABLE_POINTS:  table_points_q  <= cfg_data;
				default:           ;
			endcase
		end
	end

	// Handshake: the input stage empties whenever the result register is free or drained
	assign adv_s1     = valid_s1 && (!res_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv_s1;
	assign accept     = item_valid && item_ready;

	// Coordinates advance on every transfer, emitted or dropped
	clep_coord_ctr u_coord (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (accept),
		.table_start   (item.table_start),
		.output_format (output_format_q),
		.table_points  (table_points_q),
		.info          (info)
	);

	// Input register: load only entries that produce a result; drop the rest here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= accept && info.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && info.emit) begin
			red_s1   <= item.red_bits;
			green_s1 <= item.green_bits;
			blue_s1  <= item.blue_bits;
			last_s1  <= info.last;
		end
	end

	// Three channel converters side by side
	clep_chan_conv #(.F(F)) u_conv_r (
		.bits (red_s1), .wide_mode (output_format_q),
		.ten_code (ten_r), .wide_code (wide_r), .sat (sat_r)
	);
	clep_chan_conv #(.F(F)) u_conv_g (
		.bits (green_s1), .wide_mode (output_format_q),
		.ten_code (ten_g), .wide_code (wide_g), .sat (sat_g)
	);
	clep_chan_conv #(.F(F)) u_conv_b (
		.bits (blue_s1), .wide_mode (output_format_q),
		.ten_code (ten_b), .wide_code (wide_b), .sat (sat_b)
	);

	// Wide packing: drop any bits above the 81-bit word, or pad a shorter one with zeros at the top
	assign wide_cat = {wide_b, wide_g, wide_r};

	generate
		if (CW >= PACKED_BITS) begin : g_trunc
			assign word = wide_cat[PACKED_BITS-1:0];
		end else begin : g_pad
			assign word = {{(PACKED_BITS-CW){1'b0}}, wide_cat};
		end
	endgenerate

	always_comb begin
		if (output_format_q == FMT_WIDE) begin
			result_d.packed_low  = word[63:0];
			result_d.packed_high = word[80:64];
		end else begin
			result_d.packed_low  = {34'd0, ten_b, ten_g, ten_r};
			result_d.packed_high = '0;
		end
		result_d.saturated  = sat_r | sat_g | sat_b;
		result_d.last_entry = last_s1;
	end

	// Result register: hold until the transfer on the output side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= result_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

	// A stalled input stage behind a full, unaccepted result must block new transfers
	a_block_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && res_valid_q && !result_ready |-> !item_ready)
		else $error("input taken while both stages are stalled");

	// An entry leaving the input stage always lands in the result register
	a_advance_lands: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> res_valid_q)
		else $error("advanced entry lost");

	// Ten-bit mode never drives the upper word
	a_ten_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && output_format_q == FMT_TEN_BIT |-> result_q.packed_high == 17'd0)
		else $error("upper bits set in ten-bit mode");

endmodule

### rtl/core/clep_coord_ctr.sv
// Table coordinate counters: decide whether an entry is emitted and whether it is the last.
module clep_coord_ctr (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 table_start,
	input  logic                 output_format,
	input  logic [5:0]           table_points,
	output clep_pkg::coord_info_t info
);
	import clep_pkg::*;

	logic [5:0] coord_x_q, coord_y_q, coord_z_q;
	logic [5:0] cx, cy, cz, lim;

	assign cx  = table_start ? 6'd0 : coord_x_q;
	assign cy  = table_start ? 6'd0 : coord_y_q;
	assign cz  = table_start ? 6'd0 : coord_z_q;
	assign lim = table_points - 6'd1;

	always_comb begin
		info.last = (cx == lim) && (cy == lim) && (cz == lim);
		info.emit = 1'b1;
		// decimate 33 points to 17: keep even coordinates only
		if (output_format == FMT_WIDE && table_points == DOWNSAMPLE_POINTS) begin
			info.emit = ~(cx[0] | cy[0] | cz[0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_x_q <= '0;
			coord_y_q <= '0;
			coord_z_q <= '0;
		end else if (step) begin
			if (cx == lim) begin
				coord_x_q <= '0;
				if (cy == lim) begin
					coord_y_q <= '0;
					coord_z_q <= (cz == lim) ? 6'd0 : cz + 6'd1;
				end else begin
					coord_y_q <= cy + 6'd1;
					coord_z_q <= cz;
				end
			end else begin
				coord_x_q <= cx + 6'd1;
				coord_y_q <= cy;
				coord_z_q <= cz;
			end
		end
	end

endmodule

### rtl/core/clep_chan_conv.sv
// One channel converter: single-precision bits to a 10-bit or wide fixed-point code.
module clep_chan_conv #(
	parameter int unsigned F = 27
) (
	input  logic [31:0]  bits,
	input  logic         wide_mode,
	output logic [9:0]   ten_code,
	output logic [F-1:0] wide_code,
	output logic         sat
);
	import clep_pkg::*;

	localparam int unsigned TW = 24 + F;
	localparam int unsigned QW = TW + 1;
	localparam logic [7:0] TW8 = 8'(TW);

	logic        sign, nan_inf, is_zero;
	logic [7:0]  ex;
	logic [22:0] fr;
	logic [23:0] m;

	// ten-bit path
	logic [33:0] prod;
	logic        top;
	logic [23:0] q_t;
	logic        guard, sticky, rnd_up;
	logic [24:0] q25, ten_val;
	logic [7:0]  sh8;
	logic        ten_sat;

	// wide path
	logic [TW-1:0] t, u;
	logic [7:0]    shift1;
	logic [QW-1:0] q_w;
	logic          wide_sat;

	assign sign    = bits[31];
	assign ex      = bits[30:23];
	assign fr      = bits[22:0];
	assign nan_inf = (ex == 8'hFF);
	assign is_zero = (ex == 8'd0) && (fr == 23'd0);
	assign m       = {(ex != 8'd0), fr};

	// x*1023 as x*1024 - x, then round to 24 significant bits, ties to even
	assign prod   = {m, 10'd0} - {10'd0, m};
	assign top    = prod[33];
	assign q_t    = top ? prod[33:10] : prod[32:9];
	assign guard  = top ? prod[9] : prod[8];
	assign sticky = top ? (|prod[8:0]) : (|prod[7:0]);
	assign rnd_up = guard & (sticky | q_t[0]);
	assign q25    = {1'b0, q_t} + {24'd0, rnd_up};
	assign sh8    = 8'd150 - ex - (top ? 8'd10 : 8'd9);
	assign ten_val = (sh8 >= 8'd25) ? 25'd0 : (q25 >> sh8[4:0]);

	// x*S as (x << F) - x, then round half up by shifting one short
	assign t      = {m, {F{1'b0}}} - {{F{1'b0}}, m};
	assign shift1 = (ex == 8'd0) ? 8'd148 : (8'd149 - ex);
	assign u      = (shift1 >= TW8) ? '0 : (t >> shift1);
	assign q_w    = ({1'b0, u} + QW'(1)) >> 1;

	always_comb begin
		ten_sat  = 1'b0;
		ten_code = '0;
		if (nan_inf) begin
			ten_sat  = 1'b1;
			ten_code = (fr != 23'd0 || sign) ? 10'd0 : TOP10;
		end else if (is_zero) begin
			ten_code = '0;
		end else if (sign) begin
			ten_sat = 1'b1;
		end else if (ex >= 8'd138) begin
			ten_sat  = 1'b1;
			ten_code = TOP10;
		end else if (ex == 8'd0) begin
			ten_code = '0;
		end else if (ten_val > 25'd1023) begin
			ten_sat  = 1'b1;
			ten_code = TOP10;
		end else begin
			ten_code = ten_val[9:0];
		end
	end

	always_comb begin
		wide_sat  = 1'b0;
		wide_code = '0;
		if (nan_inf) begin
			wide_sat  = 1'b1;
			wide_code = (fr != 23'd0 || sign) ? '0 : '1;
		end else if (is_zero) begin
			wide_code = '0;
		end else if (sign) begin
			wide_sat = 1'b1;
		end else if (ex >= 8'd128) begin
			wide_sat  = 1'b1;
			wide_code = '1;
		end else if (q_w > {{(QW-F){1'b0}}, {F{1'b1}}}) begin
			wide_sat  = 1'b1;
			wide_code = '1;
		end else begin
			wide_code = q_w[F-1:0];
		end
	end

	assign sat = wide_mode ? wide_sat : ten_sat;

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the colour table entry packer.
module testbench;
	import clep_pkg::*;

	// Channel width of the wide format; the instance below uses the same value
	localparam int FRAC = 27;
	localparam logic [63:0] WIDE_TOP = (64'd1 << FRAC) - 64'd1;
	// Margin after the last result before register writes
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_PHASES = 16;
	localparam int PHASE_ITEMS = 104;
	// Table sizes swept by the random phases, each one in both formats
	localparam logic [6:0][5:0] PHASE_POINTS = {6'd5, 6'd63, 6'd2, 6'd1, 6'd0, 6'd17, 6'd33};

	typedef struct packed {
		logic        fmt;
		logic [5:0]  points;
		entry_t      stim;
		logic        typed;
		logic        emit;
		result_t     want;
	} directed_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_index = CFG_OUTPUT_FORMAT;
	logic [5:0]  cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	entry_t      item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     result;

	// Own copy of the block's registers and coordinate counters
	logic        cur_format = FMT_TEN_BIT;
	logic [5:0]  cur_points = TABLE_POINTS_RST;
	logic [5:0]  coord_x = '0;
	logic [5:0]  coord_y = '0;
	logic [5:0]  coord_z = '0;

	result_t       pending_entries[$];
	directed_row_t directed_rows[$];
	int            mismatch_count = 0;
	logic          send_calm = 1'b0;
	logic          take_calm = 1'b0;

	color_lut_entry_packer #(
		.CHANNEL_FRACTION_BITS(FRAC)
	) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Hard stop in case a transfer never completes
	initial begin : watchdog
		#500000;
		$display("simulation failed");
		$finish;
	end

	// 10-bit code: floor of the product value*1023 after rounding it to 24 significant
	// bits (nearest, ties to even), then clamp to 1023.
	function automatic logic [9:0] ten_bit_code(input logic [31:0] f, output logic clamped);
		logic [7:0]  ex;
		logic [22:0] fr;
		logic [63:0] mant, prod, q, rem, half;
		int          k, nbits, s;
		ex = f[30:23];
		fr = f[22:0];
		clamped = 1'b0;
		if (ex == 8'hFF) begin
			// NaN and minus infinity drop to zero, plus infinity goes to the top
			clamped = 1'b1;
			return (fr != 0 || f[31]) ? 10'd0 : TOP10;
		end
		if (ex == 8'd0 && fr == 23'd0)
			return 10'd0;
		if (f[31]) begin
			clamped = 1'b1;
			return 10'd0;
		end
		// From 2^11 upwards the code is certainly above the top
		if (ex >= 8'd138) begin
			clamped = 1'b1;
			return TOP10;
		end
		mant = (ex != 8'd0) ? {40'd0, 1'b1, fr} : {41'd0, fr};
		k = (ex != 8'd0) ? 150 - int'(ex) : 149;
		prod = mant * 64'd1023;
		nbits = 0;
		for (q = prod; q != 64'd0; q = q >> 1)
			nbits++;
		if (nbits > 24) begin
			s = nbits - 24;
			q = prod >> s;
			rem = prod & ((64'd1 << s) - 64'd1);
			half = 64'd1 << (s - 1);
			if (rem > half || (rem == half && q[0]))
				q = q + 64'd1;
			prod = q << s;
		end
		q = (k < 64) ? (prod >> k) : 64'd0;
		if (q > 64'd1023) begin
			clamped = 1'b1;
			return TOP10;
		end
		return q[9:0];
	endfunction

	// Wide code: exact round-half-up of value*(2^FRAC-1), clamped to the top.
	function automatic logic [FRAC-1:0] wide_code(input logic [31:0] f, output logic clamped);
		logic [7:0]  ex;
		logic [22:0] fr;
		logic [63:0] mant, q;
		int          k;
		ex = f[30:23];
		fr = f[22:0];
		clamped = 1'b0;
		if (ex == 8'hFF) begin
			clamped = 1'b1;
			return (fr != 0 || f[31]) ? '0 : WIDE_TOP[FRAC-1:0];
		end
		if (ex == 8'd0 && fr == 23'd0)
			return '0;
		if (f[31]) begin
			clamped = 1'b1;
			return '0;
		end
		if (ex >= 8'd128) begin
			clamped = 1'b1;
			return WIDE_TOP[FRAC-1:0];
		end
		mant = (ex != 8'd0) ? {40'd0, 1'b1, fr} : {41'd0, fr};
		k = (ex != 8'd0) ? 150 - int'(ex) : 149;
		// Far below one half of a code step the result is zero
		if (k > 60)
			q = 64'd0;
		else
			q = (mant * WIDE_TOP + (64'd1 << (k - 1))) >> k;
		if (q > WIDE_TOP) begin
			clamped = 1'b1;
			return WIDE_TOP[FRAC-1:0];
		end
		return q[FRAC-1:0];
	endfunction

	// Work out the packed entry for one transfer and advance the coordinates.
	// Returns 1 when the entry produces a result.
	function automatic logic pack_entry(input entry_t e, output result_t res);
		logic [5:0]      lim;
		logic [9:0]      r10, g10, b10;
		logic [FRAC-1:0] rw, gw, bw;
		logic [127:0]    wide;
		logic            cr, cg, cb, emitted;
		lim = cur_points - 6'd1;
		if (e.table_start) begin
			coord_x = '0;
			coord_y = '0;
			coord_z = '0;
		end
		res = '0;
		res.last_entry = (coord_x == lim && coord_y == lim && coord_z == lim);
		emitted = 1'b1;
		// Wide format on a 33-point table keeps only the all-even coordinates
		if (cur_format == FMT_WIDE && cur_points == DOWNSAMPLE_POINTS)
			emitted = !(coord_x[0] | coord_y[0] | coord_z[0]);
		if (cur_format == FMT_TEN_BIT) begin
			r10 = ten_bit_code(e.red_bits, cr);
			g10 = ten_bit_code(e.green_bits, cg);
			b10 = ten_bit_code(e.blue_bits, cb);
			res.packed_low = {34'd0, b10, g10, r10};
		end else begin
			rw = wide_code(e.red_bits, cr);
			gw = wide_code(e.green_bits, cg);
			bw = wide_code(e.blue_bits, cb);
			wide = 128'(rw) | (128'(gw) << FRAC) | (128'(bw) << (2 * FRAC));
			res.packed_low = wide[63:0];
			res.packed_high = wide[80:64];
		end
		res.saturated = cr | cg | cb;
		// Step red fastest; a coordinate beyond the limit runs on and wraps at 64
		if (coord_x == lim) begin
			coord_x = '0;
			if (coord_y == lim) begin
				coord_y = '0;
				coord_z = (coord_z == lim) ? 6'd0 : coord_z + 6'd1;
			end else begin
				coord_y = coord_y + 6'd1;
			end
		end else begin
			coord_x = coord_x + 6'd1;
		end
		return emitted;
	endfunction

	// Directed row whose result is typed in by hand
	function automatic void add_check(input logic fmt, input logic [5:0] points,
			input logic start, input logic [31:0] r, input logic [31:0] g,
			input logic [31:0] b, input logic emit, input logic [63:0] lo,
			input logic [16:0] hi, input logic sat, input logic last);
		directed_row_t row;
		row.fmt = fmt;
		row.points = points;
		row.stim = '{red_bits: r, green_bits: g, blue_bits: b, table_start: start};
		row.typed = 1'b1;
		row.emit = emit;
		row.want = '{packed_low: lo, packed_high: hi, saturated: sat, last_entry: last};
		directed_rows.push_back(row);
	endfunction

	// Directed row left to the predictor
	function automatic void add_probe(input logic fmt, input logic [5:0] points,
			input logic start, input logic [31:0] r, input logic [31:0] g,
			input logic [31:0] b);
		directed_row_t row;
		row = '0;
		row.fmt = fmt;
		row.points = points;
		row.stim = '{red_bits: r, green_bits: g, blue_bits: b, table_start: start};
		directed_rows.push_back(row);
	endfunction

	// Mostly values in 0..1, with a fair share of every awkward encoding
	function automatic logic [31:0] draw_channel();
		logic [31:0] bits;
		bits = $urandom;
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4, 5, 6, 7: bits[31:23] = {1'b0, 8'($urandom_range(100, 126))};
			8: bits = 32'h3F800000 + 32'($urandom_range(0, 4)) - 32'd2;
			9: bits = {bits[31], 31'd0};
			10: bits[30:23] = 8'd0;
			11: bits[31] = 1'b1;
			12: begin
				bits[30:23] = 8'hFF;
				if (bits[0])
					bits[22:0] = '0;
			end
			13: bits[31:23] = {1'b0, 8'($urandom_range(127, 140))};
			default: ;
		endcase
		return bits;
	endfunction

	// Present one entry after a random gap, hold it until the transfer, then predict
	task automatic send_entry(input entry_t e, input logic typed, input logic typed_emit,
			input result_t typed_res);
		int      gap;
		logic    emitted;
		result_t predicted;
		gap = send_calm ? 0 : $urandom_range(0, 6);
		if ($urandom_range(0, 29) == 0)
			send_calm = !send_calm;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= e;
		item_valid <= 1'b1;
		@(posedge clk);
		while (item_ready !== 1'b1) @(posedge clk);
		emitted = pack_entry(e, predicted);
		if (typed) begin
			emitted = typed_emit;
			predicted = typed_res;
		end
		if (emitted)
			pending_entries.push_back(predicted);
	endtask

	// Drop valid, wait for every outstanding result, then let the pipeline empty
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_entries.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on consecutive edges, holding the write enable high throughout
	task automatic apply_settings(input logic fmt, input logic [5:0] points);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_OUTPUT_FORMAT;
		cfg_data <= {5'd0, fmt};
		@(posedge clk);
		cfg_index <= CFG_TABLE_POINTS;
		cfg_data <= points;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_format = fmt;
		cur_points = points;
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_entries.size() == 0) begin
			$display("%0t: result with nothing expected, actual %h", $time, got);
			mismatch_count++;
			return;
		end
		want = pending_entries.pop_front();
		if (got.packed_low !== want.packed_low) begin
			$display("%0t: packed_low expected %h actual %h", $time, want.packed_low,
				got.packed_low);
			mismatch_count++;
		end
		if (got.packed_high !== want.packed_high) begin
			$display("%0t: packed_high expected %h actual %h", $time, want.packed_high,
				got.packed_high);
			mismatch_count++;
		end
		if (got.saturated !== want.saturated) begin
			$display("%0t: saturated expected %b actual %b", $time, want.saturated,
				got.saturated);
			mismatch_count++;
		end
		if (got.last_entry !== want.last_entry) begin
			$display("%0t: last_entry expected %b actual %b", $time, want.last_entry,
				got.last_entry);
			mismatch_count++;
		end
	endtask

	// Result side: stall at random, then take one transfer and check it
	initial begin : result_side
		int stall;
		@(posedge clk);
		forever begin
			stall = take_calm ? 0 : $urandom_range(0, 6);
			if ($urandom_range(0, 29) == 0)
				take_calm = !take_calm;
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (result_valid !== 1'b1) @(posedge clk);
			check_result(result);
		end
	end

	initial begin : stimulus
		entry_t        e;
		directed_row_t row;
		logic          fmt;
		logic [5:0]    points;
		int            phase, n;

		// Ten-bit format at reset settings: zeros, one, specials, clamping
		add_check(FMT_TEN_BIT, 6'd33, 1'b1, 32'h00000000, 32'h3F800000, 32'h80000000,
			1'b1, 64'h00000000000FFC00, 17'h0, 1'b0, 1'b0);
		add_check(FMT_TEN_BIT, 6'd33, 1'b0, 32'h7FC00000, 32'h7F800000, 32'hFF800000,
			1'b1, 64'h00000000000FFC00, 17'h0, 1'b1, 1'b0);
		add_check(FMT_TEN_BIT, 6'd33, 1'b0, 32'hBF800000, 32'h40000000, 32'h3F800000,
			1'b1, 64'h000000003FFFFC00, 17'h0, 1'b1, 1'b0);
		add_check(FMT_TEN_BIT, 6'd33, 1'b0, 32'h3F000000, 32'h7F7FFFFF, 32'hFFFFFFFF,
			1'b1, 64'h00000000000FFDFF, 17'h0, 1'b1, 1'b0);
		add_probe(FMT_TEN_BIT, 6'd33, 1'b0, 32'h3F7FFFFF, 32'h007FFFFF, 32'h3A802008);
		add_probe(FMT_TEN_BIT, 6'd33, 1'b0, 32'h3F800001, 32'h00000001, 32'h447FC000);
		add_probe(FMT_TEN_BIT, 6'd33, 1'b0, 32'h3A800000, 32'h3A804020, 32'h3F7FC010);
		// Single-point table: every entry is the last one
		add_check(FMT_TEN_BIT, 6'd1, 1'b1, 32'h3F800000, 32'h00000000, 32'h00000000,
			1'b1, 64'h00000000000003FF, 17'h0, 1'b0, 1'b1);
		add_check(FMT_TEN_BIT, 6'd1, 1'b0, 32'h00000000, 32'h00000000, 32'h3F800000,
			1'b1, 64'h000000003FF00000, 17'h0, 1'b0, 1'b1);
		// Wide format, 33 points: odd coordinates produce nothing
		add_check(FMT_WIDE, 6'd33, 1'b1, 32'h3F800000, 32'h00000000, 32'h7F800000,
			1'b1, 64'hFFC0000007FFFFFF, 17'h1FFFF, 1'b1, 1'b0);
		add_check(FMT_WIDE, 6'd33, 1'b0, 32'h3F800000, 32'h3F800000, 32'h3F800000,
			1'b0, 64'h0, 17'h0, 1'b0, 1'b0);
		add_probe(FMT_WIDE, 6'd33, 1'b0, 32'h3F000000, 32'h7F7FFFFF, 32'h00000001);
		add_probe(FMT_WIDE, 6'd33, 1'b0, 32'h7FC00001, 32'h00000000, 32'h3F000000);
		add_probe(FMT_WIDE, 6'd33, 1'b0, 32'h3F7FFFFF, 32'h80000001, 32'h3E800000);
		// Wide format, 17 points: every entry is emitted
		add_check(FMT_WIDE, 6'd17, 1'b1, 32'h00000000, 32'h3F800000, 32'h00000000,
			1'b1, 64'h003FFFFFF8000000, 17'h0, 1'b0, 1'b0);
		add_probe(FMT_WIDE, 6'd17, 1'b0, 32'h43000000, 32'h3F000001, 32'h00400000);
		add_probe(FMT_WIDE, 6'd17, 1'b0, 32'h3EAAAAAB, 32'h3DCCCCCD, 32'h7F000000);
		// Whole 2x2x2 table, ending on its last entry
		add_check(FMT_TEN_BIT, 6'd2, 1'b1, 32'h00000000, 32'h00000000, 32'h00000000,
			1'b1, 64'h0, 17'h0, 1'b0, 1'b0);
		add_probe(FMT_TEN_BIT, 6'd2, 1'b0, 32'h3E000000, 32'h3F400000, 32'h3C000000);
		add_probe(FMT_TEN_BIT, 6'd2, 1'b0, 32'h3F7FE000, 32'h3B000000, 32'h3D800000);
		add_probe(FMT_TEN_BIT, 6'd2, 1'b0, 32'h00000000, 32'h3F800000, 32'h3E99999A);
		add_probe(FMT_TEN_BIT, 6'd2, 1'b0, 32'h3F19999A, 32'h3E4CCCCD, 32'h3F666666);
		add_probe(FMT_TEN_BIT, 6'd2, 1'b0, 32'h3C800000, 32'h3F7F0000, 32'h80000000);
		add_probe(FMT_TEN_BIT, 6'd2, 1'b0, 32'h3F2AAAAB, 32'h3EAAAAAB, 32'h3DE38E39);
		add_check(FMT_TEN_BIT, 6'd2, 1'b0, 32'h3F800000, 32'h3F800000, 32'h3F800000,
			1'b1, 64'h000000003FFFFFFF, 17'h0, 1'b0, 1'b1);

		// Hold reset, then release it on an edge
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, reprogramming only between idle stretches
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.fmt != cur_format || row.points != cur_points) begin
				settle();
				apply_settings(row.fmt, row.points);
			end
			send_entry(row.stim, row.typed, row.emit, row.want);
		end

		// Random tables: each phase mostly opens a fresh table; the rest carry the
		// coordinates over, which may leave them beyond a smaller limit
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase < 14) begin
				fmt = phase[0];
				points = PHASE_POINTS[phase / 2];
			end else begin
				fmt = 1'($urandom_range(0, 1));
				points = ($urandom_range(0, 1) == 1) ? 6'($urandom_range(0, 63))
					: DOWNSAMPLE_POINTS;
			end
			settle();
			apply_settings(fmt, points);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				e.red_bits = draw_channel();
				e.green_bits = draw_channel();
				e.blue_bits = draw_channel();
				e.table_start = (n == 0) ? ($urandom_range(0, 3) != 0)
					: ($urandom_range(0, 49) == 0);
				send_entry(e, 1'b0, 1'b0, '0);
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
